// File: hdl/rlfmc_pkg.sv
// Shared types, codes and helpers for the RGB LED fade/mode controller.
`timescale 1ns / 1ps
`default_nettype none

package rlfmc_pkg;

  localparam int NUM_CH     = 3;
  localparam int CH_W       = 8;
  localparam int OP_W       = 4;
  localparam int MODE_W     = 5;
  localparam int STEP_W     = 16;
  localparam int WAIT_SEC_W = 12;
  localparam int WAIT_W     = 22;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int TICKS_PER_SECOND = 1000;

  // command queue between decode and execute
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // restoring divider, one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(CH_W);

  localparam logic [STEP_W-1:0]     STEP_RESET     = STEP_W'(5);
  localparam logic [STEP_W-1:0]     STEP_FADE_UP   = STEP_W'(5);
  localparam logic [WAIT_SEC_W-1:0] WAIT_SEC_RESET = WAIT_SEC_W'(60);
  localparam logic [WAIT_W-1:0]     WAIT_MAX       = '1;
  localparam logic [MODE_W-1:0]     PROFILE_LIMIT  = MODE_W'(20);

  // opcodes
  localparam logic [OP_W-1:0] OP_TICK     = OP_W'(0);
  localparam logic [OP_W-1:0] OP_SET      = OP_W'(1);
  localparam logic [OP_W-1:0] OP_INC      = OP_W'(2);
  localparam logic [OP_W-1:0] OP_DEC      = OP_W'(3);
  localparam logic [OP_W-1:0] OP_BRIGHT   = OP_W'(4);
  localparam logic [OP_W-1:0] OP_FADE     = OP_W'(5);
  localparam logic [OP_W-1:0] OP_PLAY     = OP_W'(6);
  localparam logic [OP_W-1:0] OP_AUTONEXT = OP_W'(7);
  localparam logic [OP_W-1:0] OP_PROFILE  = OP_W'(8);
  localparam logic [OP_W-1:0] OP_TOGGLE   = OP_W'(9);
  localparam logic [OP_W-1:0] OP_SYNC     = OP_W'(10);

  // modes
  localparam logic [MODE_W-1:0] MODE_OFF       = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_FADE_DOWN = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_WHITE     = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_FADE_UP   = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_HOLD      = MODE_W'(4);
  localparam logic [MODE_W-1:0] MODE_TABLE_A   = MODE_W'(5);
  localparam logic [MODE_W-1:0] MODE_TABLE_B   = MODE_W'(6);
  localparam logic [MODE_W-1:0] MODE_TABLE_C   = MODE_W'(7);
  localparam logic [MODE_W-1:0] MODE_TABLE_D   = MODE_W'(8);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_SECONDS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = CFG_IDX_W'(2);

  typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

  // decoded command word
  typedef struct packed {
    logic [OP_W-1:0]   op;
    rgb_t              rgb;
    logic [NUM_CH-1:0] mask;
    logic              mask_all;
    logic              mask_any;
    logic              flag;
    logic [CH_W-1:0]   divisor;
    logic [MODE_W-1:0] profile;
    logic              profile_play;
  } cmd_t;

  // wait period in ticks, saturated to the countdown width
  function automatic logic [WAIT_W-1:0] wait_len(input logic [WAIT_SEC_W-1:0] secs);
    logic [31:0] prod;
    prod = 32'(secs) * 32'(TICKS_PER_SECOND);
    if (prod > 32'(WAIT_MAX)) begin
      wait_len = WAIT_MAX;
    end else begin
      wait_len = prod[WAIT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/rlfmc_ifs.sv
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface rlfmc_in_if import rlfmc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       opcode;
  logic [CH_W-1:0]       red;
  logic [CH_W-1:0]       green;
  logic [CH_W-1:0]       blue;
  logic [CH_W-1:0]       value;
  logic [NUM_CH-1:0]     channel_mask;
  logic                  flag;

  modport source (output valid, opcode, red, green, blue, value, channel_mask, flag,
                  input ready);
  modport sink   (input valid, opcode, red, green, blue, value, channel_mask, flag,
                  output ready);
endinterface

interface rlfmc_out_if import rlfmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   level_red;
  logic [CH_W-1:0]   level_green;
  logic [CH_W-1:0]   level_blue;
  logic [MODE_W-1:0] mode;
  logic              at_target;
  logic              is_lit;
  logic              mode_report;

  modport source (output valid, level_red, level_green, level_blue, mode, at_target,
                  is_lit, mode_report, input ready);
  modport sink   (input valid, level_red, level_green, level_blue, mode, at_target,
                  is_lit, mode_report, output ready);
endinterface

`default_nettype wire

// File: hdl/rlfmc_front.sv
// Front end: accepts command words and decodes them for the queue.
`timescale 1ns / 1ps
`default_nettype none

module rlfmc_front import rlfmc_pkg::*; (
  rlfmc_in_if.sink in_ch,
  input  wire      q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_cmd.op           = in_ch.opcode;
    q_cmd.rgb          = {in_ch.blue, in_ch.green, in_ch.red};
    q_cmd.mask         = in_ch.channel_mask;
    q_cmd.mask_all     = &in_ch.channel_mask;
    q_cmd.mask_any     = |in_ch.channel_mask;
    q_cmd.flag         = in_ch.flag;
    // zero divisor counts as one
    q_cmd.divisor      = (in_ch.value == '0) ? CH_W'(1) : in_ch.value;
    // profiles of PROFILE_LIMIT or more fall back to held colour
    if (in_ch.value >= CH_W'(PROFILE_LIMIT)) begin
      q_cmd.profile = MODE_HOLD;
    end else begin
      q_cmd.profile = in_ch.value[MODE_W-1:0];
    end
    q_cmd.profile_play = (q_cmd.profile > MODE_HOLD);
  end

endmodule

`default_nettype wire

// File: hdl/rlfmc_queue.sv
// Short command queue between decode and execute.
`timescale 1ns / 1ps
`default_nettype none

module rlfmc_queue import rlfmc_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  cmd_t push_cmd,
  output logic full,
  input  wire  pop,
  output logic valid,
  output cmd_t head
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rlfmc_div.sv
// Three-lane restoring divider for the brightness scaling, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rlfmc_div import rlfmc_pkg::*; (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  input  rgb_t            dividend,
  input  wire [CH_W-1:0]  divisor,
  output logic            done,
  output rgb_t            quot
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  rgb_t                   dvd_r, dvd_nxt;   // dividend shifts out, quotient shifts in
  rgb_t                   rem_r, rem_nxt;
  logic [CH_W-1:0]        dsr_r;
  logic [NUM_CH-1:0][CH_W:0] trial;
  logic [NUM_CH-1:0][CH_W:0] diff;

  assign done = done_r;
  assign quot = dvd_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    for (int i = 0; i < NUM_CH; i++) begin
      trial[i] = {rem_r[i], dvd_r[i][CH_W-1]};
      diff[i]  = trial[i] - {1'b0, dsr_r};
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (trial[i] >= {1'b0, dsr_r}) begin
          rem_nxt[i] = diff[i][CH_W-1:0];
          dvd_nxt[i] = {dvd_r[i][CH_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = trial[i][CH_W-1:0];
          dvd_nxt[i] = {dvd_r[i][CH_W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(CH_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rlfmc_back.sv
// Back end: executes commands and ticks, scales the levels, holds the result word.
`timescale 1ns / 1ps
`default_nettype none

module rlfmc_back import rlfmc_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  input  cmd_t                 q_cmd,
  output logic                 q_pop,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_idx,
  input  wire [CFG_DATA_W-1:0] cfg_data,
  rlfmc_out_if.source          out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]        state_r, state_nxt;

  rgb_t              cur_r, cur_nxt;
  rgb_t              tgt_r, tgt_nxt;
  logic [CH_W-1:0]   bdiv_r, bdiv_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              fade_r, fade_nxt;
  logic              sync_r, sync_nxt;
  logic              play_r, play_nxt;
  logic [STEP_W-1:0] sper_r, sper_nxt;
  logic [STEP_W-1:0] scd_r, scd_nxt;
  logic [WAIT_W-1:0] wlen_r, wlen_nxt;
  logic [WAIT_W-1:0] wcd_r, wcd_nxt;
  logic              inv_r, inv_nxt;
  logic              rep_nxt;

  // snapshot of the word under scaling
  logic [MODE_W-1:0] res_mode_r;
  logic              res_at_r;
  logic              res_rep_r;

  logic              out_valid_r;
  logic              out_load;
  logic              exec;
  logic              step_due;
  logic              wait_due;
  logic              div_done;
  rgb_t              div_quot;

  assign q_pop = (state_r == ST_IDLE) && q_valid;
  assign exec  = q_pop;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  rlfmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (exec),
    .dividend (cur_nxt),
    .divisor  (bdiv_nxt),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (exec) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state update for one word and for configuration writes
  always_comb begin
    cur_nxt  = cur_r;
    tgt_nxt  = tgt_r;
    bdiv_nxt = bdiv_r;
    mode_nxt = mode_r;
    fade_nxt = fade_r;
    sync_nxt = sync_r;
    play_nxt = play_r;
    sper_nxt = sper_r;
    scd_nxt  = scd_r;
    wlen_nxt = wlen_r;
    wcd_nxt  = wcd_r;
    inv_nxt  = inv_r;
    rep_nxt  = 1'b0;
    step_due = (scd_r == '0);
    wait_due = 1'b0;

    if (exec) begin
      unique case (q_cmd.op)
        OP_TICK: begin
          if (!step_due) scd_nxt = scd_r - 1'b1;
          if (play_r) begin
            if (wcd_r == '0) begin
              wait_due = 1'b1;
            end else begin
              wcd_nxt = wcd_r - 1'b1;
            end
          end
          if (cur_r != tgt_r) begin
            if (fade_r) begin
              if (step_due) begin
                scd_nxt = sper_r;
                for (int i = 0; i < NUM_CH; i++) begin
                  if (tgt_r[i] > cur_r[i]) begin
                    cur_nxt[i] = cur_r[i] + 1'b1;
                  end else if (tgt_r[i] < cur_r[i]) begin
                    cur_nxt[i] = cur_r[i] - 1'b1;
                  end
                end
              end
            end else begin
              cur_nxt = tgt_r;
            end
          end
          // mode machine
          if (sync_r || (play_r && wait_due)) begin
            wcd_nxt = wlen_r;
            unique case (mode_r)
              MODE_OFF: begin
                tgt_nxt  = '0;
                bdiv_nxt = CH_W'(1);
                fade_nxt = 1'b0;
                sync_nxt = 1'b0;
              end
              MODE_FADE_DOWN: begin
                tgt_nxt  = '0;
                bdiv_nxt = CH_W'(1);
                fade_nxt = 1'b1;
                sync_nxt = 1'b1;
                if (cur_nxt == '0) begin
                  mode_nxt = MODE_OFF;
                  rep_nxt  = 1'b1;
                end
              end
              MODE_WHITE: begin
                tgt_nxt  = '1;
                bdiv_nxt = CH_W'(1);
                fade_nxt = 1'b0;
                sync_nxt = 1'b0;
              end
              MODE_FADE_UP: begin
                tgt_nxt  = '1;
                bdiv_nxt = CH_W'(1);
                fade_nxt = 1'b1;
                sper_nxt = STEP_FADE_UP;
                sync_nxt = 1'b1;
                if (cur_nxt == '1) begin
                  mode_nxt = MODE_WHITE;
                  rep_nxt  = 1'b1;
                end
              end
              MODE_HOLD, MODE_TABLE_A, MODE_TABLE_B, MODE_TABLE_C, MODE_TABLE_D: begin
              end
              default: mode_nxt = MODE_OFF;
            endcase
            if (mode_nxt > MODE_FADE_UP) sync_nxt = 1'b0;
          end
        end
        OP_SET: begin
          if (q_cmd.mask_all) begin
            if (cur_r != q_cmd.rgb) begin
              tgt_nxt  = q_cmd.rgb;
              sync_nxt = q_cmd.flag;
            end
          end else if (q_cmd.mask_any) begin
            for (int i = 0; i < NUM_CH; i++) begin
              if (q_cmd.mask[i]) tgt_nxt[i] = q_cmd.rgb[i];
            end
            sync_nxt = q_cmd.flag;
          end
          // force: jump straight to the new target
          if (q_cmd.mask_any && q_cmd.flag) cur_nxt = tgt_nxt;
        end
        OP_INC: begin
          if (q_cmd.mask_any) begin
            for (int i = 0; i < NUM_CH; i++) begin
              if (q_cmd.mask[i] && (cur_r[i] != '1)) tgt_nxt[i] = cur_r[i] + 1'b1;
            end
            sync_nxt = 1'b1;
          end
        end
        OP_DEC: begin
          if (q_cmd.mask_any) begin
            for (int i = 0; i < NUM_CH; i++) begin
              if (q_cmd.mask[i] && (cur_r[i] != '0)) tgt_nxt[i] = cur_r[i] - 1'b1;
            end
            sync_nxt = 1'b1;
          end
        end
        OP_BRIGHT: bdiv_nxt = q_cmd.divisor;
        OP_FADE: begin
          fade_nxt = q_cmd.flag;
          sync_nxt = 1'b1;
        end
        OP_PLAY: begin
          play_nxt = q_cmd.flag;
          sync_nxt = 1'b1;
        end
        OP_AUTONEXT, OP_SYNC: sync_nxt = 1'b1;
        OP_PROFILE: begin
          mode_nxt = q_cmd.profile;
          if (q_cmd.profile_play) play_nxt = 1'b1;
          sync_nxt = 1'b1;
          rep_nxt  = 1'b1;
        end
        OP_TOGGLE: begin
          if (mode_r != MODE_OFF) begin
            mode_nxt = q_cmd.flag ? MODE_FADE_DOWN : MODE_OFF;
          end else begin
            mode_nxt = q_cmd.flag ? MODE_FADE_UP : MODE_WHITE;
          end
          sync_nxt = 1'b1;
          rep_nxt  = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_STEP_PERIOD: begin
          sper_nxt = cfg_data[STEP_W-1:0];
          scd_nxt  = cfg_data[STEP_W-1:0];
        end
        CFG_WAIT_SECONDS: begin
          wlen_nxt = wait_len(cfg_data[WAIT_SEC_W-1:0]);
          wcd_nxt  = wait_len(cfg_data[WAIT_SEC_W-1:0]);
        end
        CFG_INVERT: inv_nxt = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      tgt_r       <= '0;
      bdiv_r      <= CH_W'(1);
      mode_r      <= MODE_OFF;
      fade_r      <= 1'b1;
      sync_r      <= 1'b1;
      play_r      <= 1'b1;
      sper_r      <= STEP_RESET;
      scd_r       <= '0;
      wlen_r      <= wait_len(WAIT_SEC_RESET);
      wcd_r       <= '0;
      inv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      tgt_r   <= tgt_nxt;
      bdiv_r  <= bdiv_nxt;
      mode_r  <= mode_nxt;
      fade_r  <= fade_nxt;
      sync_r  <= sync_nxt;
      play_r  <= play_nxt;
      sper_r  <= sper_nxt;
      scd_r   <= scd_nxt;
      wlen_r  <= wlen_nxt;
      wcd_r   <= wcd_nxt;
      inv_r   <= inv_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_mode_r <= mode_nxt;
      res_at_r   <= (cur_nxt == tgt_nxt);
      res_rep_r  <= rep_nxt;
    end
    if (out_load) begin
      out_ch.level_red   <= inv_r ? ~div_quot[0] : div_quot[0];
      out_ch.level_green <= inv_r ? ~div_quot[1] : div_quot[1];
      out_ch.level_blue  <= inv_r ? ~div_quot[2] : div_quot[2];
      out_ch.mode        <= res_mode_r;
      out_ch.at_target   <= res_at_r;
      out_ch.is_lit      <= (res_mode_r != MODE_OFF);
      out_ch.mode_report <= res_rep_r;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

`default_nettype wire

// File: hdl/rgb_led_fade_mode_controller.sv
// Top level of the RGB LED fade/mode controller.
`timescale 1ns / 1ps
`default_nettype none

// Three-channel LED controller. Each word on in_ch is either a millisecond
// tick (opcode 0) or a command (set colour, step up/down, brightness, fade,
// play, auto-next, profile, toggle, sync); each word gives exactly one word on
// out_ch with the three PWM levels (current colour divided by the brightness
// divisor, inverted when invert_output is set), the mode number, the
// at-target and lit flags and the mode-report flag. On a tick the colour
// walks one step per channel every step_period+1 ticks while fading, or jumps
// to its target otherwise; the mode machine (off, fade down, white, fade up,
// held colour; table modes act as held colour) runs once per wait period
// while playing, or on the next tick when a sync is pending. A paused block
// keeps the remaining wait. Each word passes through execute, the bit-serial
// restoring divider that scales the levels, the divider's done flag and the
// output register load; the next word is not executed before that load. A
// 2-word queue after the decode stage lets in_ch keep accepting while a word
// is in execution, and the output register lets the next word execute while
// a result waits on out_ch. Configuration (cfg_idx 0 step_period,
// 1 wait_seconds, 2 invert_output) is to be written with cfg_we only while no
// word is in flight, which the block does not enforce; writing step_period or
// wait_seconds also reloads the matching countdown. Reset: rst_n, synchronous.

module rgb_led_fade_mode_controller import rlfmc_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  rlfmc_in_if.sink             in_ch,
  rlfmc_out_if.source          out_ch,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_idx,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_in_cmd;
  cmd_t q_head;

  // decode
  rlfmc_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in_cmd)
  );

  // decoupling queue
  rlfmc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // execute, scale, output register
  rlfmc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_head),
    .q_pop    (q_pop),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// File: tb/sv/rgb_led_fade_mode_controller_tb.sv
// Self-checking bench for the RGB LED fade/mode controller: directed table, then random scenes.
`timescale 1ns / 1ps

module rgb_led_fade_mode_controller_tb;
  import rlfmc_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 11;
  localparam int LONG_HOLD    = 150;   // receiver hold-off, long enough to back up in_ch
  localparam int DRAIN_CYCLES = 40;    // extra settling time after the last result word
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_WORDS  = 104;

  localparam logic [OP_W-1:0]   OP_UNUSED    = OP_W'(15);
  localparam logic [STEP_W-1:0] FADE_UP_STEP = STEP_W'(5);
  localparam logic [CH_W-1:0]   PROFILE_CAP  = CH_W'(20);
  localparam logic [CH_W-1:0]   FULL         = CH_W'(255);

  typedef logic [NUM_CH-1:0][CH_W-1:0] colour_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [CH_W-1:0]   value;
    logic [NUM_CH-1:0] mask;
    logic              flag;
  } cmd_word_t;

  typedef struct packed {
    logic [CH_W-1:0]   lvl_r;
    logic [CH_W-1:0]   lvl_g;
    logic [CH_W-1:0]   lvl_b;
    logic [MODE_W-1:0] mode;
    logic              at_target;
    logic              is_lit;
    logic              mode_report;
  } led_word_t;

  typedef struct packed {
    cmd_word_t cmd;
    logic      typed;   // 1: want holds the expected word, else the predictor decides
    led_word_t want;
  } plan_row_t;

  localparam led_word_t BY_MODEL = '0;

  // Directed walk from reset (step 5, wait 60 s, no inversion).
  localparam int PLAN_LEN = 28;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // first tick: off mode runs, everything dark
    '{'{OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, MODE_OFF, 1'b1, 1'b0, 1'b0}},
    // toggle from off without fade goes to white
    '{'{OP_TOGGLE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, MODE_WHITE, 1'b1, 1'b1, 1'b1}},
    '{'{OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, MODE_WHITE, 1'b0, 1'b1, 1'b0}},
    // no fade: jump straight to white
    '{'{OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b1,
      '{8'd255, 8'd255, 8'd255, MODE_WHITE, 1'b1, 1'b1, 1'b0}},
    // divisor 0 is taken as 1
    '{'{OP_BRIGHT, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b1,
      '{8'd255, 8'd255, 8'd255, MODE_WHITE, 1'b1, 1'b1, 1'b0}},
    '{'{OP_BRIGHT, 8'd0, 8'd0, 8'd0, 8'd255, 3'b000, 1'b0}, 1'b1,
      '{8'd1, 8'd1, 8'd1, MODE_WHITE, 1'b1, 1'b1, 1'b0}},
    '{'{OP_BRIGHT, 8'd0, 8'd0, 8'd0, 8'd7, 3'b000, 1'b0}, 1'b0, BY_MODEL},
    // step up at full scale leaves the targets alone
    '{'{OP_INC, 8'd0, 8'd0, 8'd0, 8'd0, 3'b111, 1'b0}, 1'b0, BY_MODEL},
    '{'{OP_DEC, 8'd0, 8'd0, 8'd0, 8'd0, 3'b101, 1'b0}, 1'b0, BY_MODEL},
    '{'{OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b0, BY_MODEL},
    // forced set: current jumps to the new colour
    '{'{OP_SET, 8'd0, 8'd128, 8'd255, 8'd0, 3'b111, 1'b1}, 1'b1,
      '{8'd0, 8'd128, 8'd255, MODE_WHITE, 1'b1, 1'b1, 1'b0}},
    // full-mask set to the colour already shown changes nothing
    '{'{OP_SET, 8'd0, 8'd128, 8'd255, 8'd0, 3'b111, 1'b0}, 1'b0, BY_MODEL},
    // empty mask
    '{'{OP_SET, 8'd9, 8'd9, 8'd9, 8'd0, 3'b000, 1'b1}, 1'b0, BY_MODEL},
    '{'{OP_SET, 8'd0, 8'd7, 8'd0, 8'd0, 3'b010, 1'b0}, 1'b0, BY_MODEL},
    // profile of 20 or more is held colour
    '{'{OP_PROFILE, 8'd0, 8'd0, 8'd0, 8'd20, 3'b000, 1'b0}, 1'b1,
      '{8'd0, 8'd128, 8'd255, MODE_HOLD, 1'b0, 1'b1, 1'b1}},
    '{'{OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b0, BY_MODEL},
    // table mode, acts as held colour
    '{'{OP_PROFILE, 8'd0, 8'd0, 8'd0, 8'd6, 3'b000, 1'b0}, 1'b0, BY_MODEL},
    '{'{OP_FADE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b1}, 1'b0, BY_MODEL},
    '{'{OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b0, BY_MODEL},
    // modes past the table drop to off on the next run
    '{'{OP_PROFILE, 8'd0, 8'd0, 8'd0, 8'd19, 3'b000, 1'b0}, 1'b0, BY_MODEL},
    '{'{OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b0, BY_MODEL},
    // paused: wait countdown holds
    '{'{OP_PLAY, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b0, BY_MODEL},
    '{'{OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b0, BY_MODEL},
    '{'{OP_AUTONEXT, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b0, BY_MODEL},
    '{'{OP_SYNC, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0}, 1'b0, BY_MODEL},
    '{'{OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'b111, 1'b1}, 1'b0, BY_MODEL},
    '{'{OP_PLAY, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b1}, 1'b0, BY_MODEL},
    '{'{OP_TOGGLE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b1}, 1'b0, BY_MODEL}
  };

  // Register settings per random phase; the last one runs without idling.
  localparam logic [STEP_W-1:0]     PHASE_STEP [NUM_PHASES] =
    '{16'd0, 16'd2, 16'hFFFF, 16'd1, 16'd3, 16'd0};
  localparam logic [WAIT_SEC_W-1:0] PHASE_SECS [NUM_PHASES] =
    '{12'd0, 12'd1, 12'd3600, 12'd4095, 12'd2, 12'd0};
  localparam logic                  PHASE_INV  [NUM_PHASES] =
    '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rlfmc_in_if  in_ch ();
  rlfmc_out_if out_ch ();

  rgb_led_fade_mode_controller dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Controller mirror: registers and state as the block should hold them.
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0]     m_step_period;
  logic [WAIT_SEC_W-1:0] m_wait_secs;
  logic                  m_flip_levels;
  colour_t               m_cur;
  colour_t               m_tgt;
  logic [CH_W-1:0]       m_div;
  logic [MODE_W-1:0]     m_mode;
  logic                  m_fade;
  logic                  m_sync;
  logic                  m_play;
  logic                  m_auto;
  logic [STEP_W-1:0]     m_step_cd;
  logic [WAIT_W-1:0]     m_wait_cd;

  led_word_t pending_levels [$];   // expected result words, oldest first
  int        words_taken = 0;
  int        mismatches  = 0;
  bit        calm        = 1'b0;   // no idling on either side
  bit        hold_long   = 1'b0;   // asks the receiver for one long hold-off

  // wait period in ticks, clipped to the 22-bit countdown
  function automatic logic [WAIT_W-1:0] wait_ticks();
    int unsigned prod;
    prod = int'(m_wait_secs) * TICKS_PER_SECOND;
    if (prod > (2 ** WAIT_W) - 1) return '1;
    return WAIT_W'(prod);
  endfunction

  function automatic bit colour_settled();
    return m_cur == m_tgt;
  endfunction

  function automatic void aim_all(logic [CH_W-1:0] lvl);
    m_tgt = {NUM_CH{lvl}};
    m_div = CH_W'(1);
  endfunction

  // one pass of the mode machine; 1 when it moved to a reported mode
  function automatic bit run_mode_machine();
    bit rep;
    rep = 1'b0;
    case (m_mode)
      MODE_OFF: begin
        aim_all('0);
        m_fade = 1'b0;
        m_sync = 1'b0;
      end
      MODE_FADE_DOWN: begin
        aim_all('0);
        m_fade = 1'b1;
        m_sync = 1'b1;
        if (colour_settled()) begin
          m_mode = MODE_OFF;
          rep = 1'b1;
        end
      end
      MODE_WHITE: begin
        aim_all(FULL);
        m_fade = 1'b0;
        m_sync = 1'b0;
      end
      MODE_FADE_UP: begin
        aim_all(FULL);
        m_fade = 1'b1;
        m_step_period = FADE_UP_STEP;
        m_sync = 1'b1;
        if (colour_settled()) begin
          m_mode = MODE_WHITE;
          rep = 1'b1;
        end
      end
      MODE_HOLD, MODE_TABLE_A, MODE_TABLE_B, MODE_TABLE_C, MODE_TABLE_D: ;
      default: m_mode = MODE_OFF;
    endcase
    if (m_mode > MODE_FADE_UP) m_sync = 1'b0;
    return rep;
  endfunction

  function automatic bit take_tick();
    bit step_due;
    bit wait_due;
    step_due = (m_step_cd == '0);
    wait_due = 1'b0;
    if (!step_due) m_step_cd = m_step_cd - 1'b1;
    if (m_play) begin
      if (m_wait_cd == '0) wait_due = 1'b1;
      else m_wait_cd = m_wait_cd - 1'b1;
    end
    if (!colour_settled()) begin
      if (!m_fade) begin
        m_cur = m_tgt;
      end else if (step_due) begin
        m_step_cd = m_step_period;
        for (int c = 0; c < NUM_CH; c++) begin
          if (m_tgt[c] > m_cur[c]) m_cur[c] = m_cur[c] + 1'b1;
          else if (m_tgt[c] < m_cur[c]) m_cur[c] = m_cur[c] - 1'b1;
        end
      end
    end
    if (m_sync || (m_play && wait_due)) begin
      m_wait_cd = wait_ticks();
      return run_mode_machine();
    end
    return 1'b0;
  endfunction

  function automatic logic [CH_W-1:0] pwm_duty(logic [CH_W-1:0] lvl);
    logic [CH_W-1:0] q;
    q = lvl / ((m_div == '0) ? CH_W'(1) : m_div);
    return m_flip_levels ? FULL - q : q;
  endfunction

  // Applies one command word to the mirror and returns the word the block should emit.
  function automatic led_word_t advance_controller(cmd_word_t w);
    colour_t   given;
    bit        rep;
    led_word_t r;
    given = {w.blue, w.green, w.red};
    rep = 1'b0;
    case (w.opcode)
      OP_TICK: rep = take_tick();
      OP_SET: begin
        if (&w.mask) begin
          // full mask only takes effect when the shown colour differs
          if (m_cur != given) begin
            m_tgt = given;
            m_sync = w.flag;
          end
        end else if (|w.mask) begin
          for (int c = 0; c < NUM_CH; c++) if (w.mask[c]) m_tgt[c] = given[c];
          m_sync = w.flag;
        end
        if (|w.mask && w.flag) m_cur = m_tgt;
      end
      OP_INC: begin
        if (|w.mask) begin
          for (int c = 0; c < NUM_CH; c++)
            if (w.mask[c] && m_cur[c] != FULL) m_tgt[c] = m_cur[c] + 1'b1;
          m_sync = 1'b1;
        end
      end
      OP_DEC: begin
        if (|w.mask) begin
          for (int c = 0; c < NUM_CH; c++)
            if (w.mask[c] && m_cur[c] != '0) m_tgt[c] = m_cur[c] - 1'b1;
          m_sync = 1'b1;
        end
      end
      OP_BRIGHT: m_div = (w.value == '0) ? CH_W'(1) : w.value;
      OP_FADE: begin
        m_fade = w.flag;
        m_sync = 1'b1;
      end
      OP_PLAY: begin
        m_play = w.flag;
        m_sync = 1'b1;
      end
      OP_AUTONEXT: begin
        m_auto = w.flag;
        m_sync = 1'b1;
      end
      OP_PROFILE: begin
        m_mode = (w.value >= PROFILE_CAP) ? MODE_HOLD : w.value[MODE_W-1:0];
        if (m_mode > MODE_HOLD) begin
          m_play = 1'b1;
          m_auto = 1'b1;
        end
        m_sync = 1'b1;
        rep = 1'b1;
      end
      OP_TOGGLE: begin
        if (m_mode != MODE_OFF) m_mode = w.flag ? MODE_FADE_DOWN : MODE_OFF;
        else m_mode = w.flag ? MODE_FADE_UP : MODE_WHITE;
        m_sync = 1'b1;
        rep = 1'b1;
      end
      OP_SYNC: m_sync = 1'b1;
      default: ;
    endcase
    r.lvl_r       = pwm_duty(m_cur[0]);
    r.lvl_g       = pwm_duty(m_cur[1]);
    r.lvl_b       = pwm_duty(m_cur[2]);
    r.mode        = m_mode;
    r.at_target   = colour_settled();
    r.is_lit      = (m_mode != MODE_OFF);
    r.mode_report = rep;
    return r;
  endfunction

  function automatic void mirror_config(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_STEP_PERIOD: begin
        m_step_period = data[STEP_W-1:0];
        m_step_cd     = data[STEP_W-1:0];
      end
      CFG_WAIT_SECONDS: begin
        m_wait_secs = data[WAIT_SEC_W-1:0];
        m_wait_cd   = wait_ticks();
      end
      CFG_INVERT: m_flip_levels = data[0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  function automatic cmd_word_t any_word();
    cmd_word_t w;
    w.opcode = OP_W'($urandom_range(0, 15));
    w.red    = CH_W'($urandom_range(0, 255));
    w.green  = CH_W'($urandom_range(0, 255));
    w.blue   = CH_W'($urandom_range(0, 255));
    // small values half the time so profiles land on real modes
    w.value  = $urandom_range(0, 1) ? CH_W'($urandom_range(0, 24))
                                    : CH_W'($urandom_range(0, 255));
    w.mask   = NUM_CH'($urandom_range(0, 7));
    w.flag   = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Offers one word, waits for the handshake, records the expectation, then maybe idles.
  task automatic push_word(cmd_word_t w, logic typed = 1'b0, led_word_t want = '0);
    led_word_t pred;
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= w.opcode;
    in_ch.red          <= w.red;
    in_ch.green        <= w.green;
    in_ch.blue         <= w.blue;
    in_ch.value        <= w.value;
    in_ch.channel_mask <= w.mask;
    in_ch.flag         <= w.flag;
    do @(posedge clk); while (!in_ch.ready);
    pred = advance_controller(w);
    pending_levels.push_back(typed ? want : pred);
    words_taken++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic push_ticks(int n);
    cmd_word_t w;
    repeat (n) begin
      w = any_word();
      w.opcode = OP_TICK;
      push_word(w);
    end
  endtask

  // One random scene: a full fade sequence, noise, a tick run or a broken sequence.
  task automatic play_scene();
    cmd_word_t w;
    int        pick;
    pick = $urandom_range(0, 9);
    w = any_word();
    if (pick < 4) begin
      // pin the colour a few steps from the far end, then toggle into the fade
      w.opcode = OP_SET;
      w.mask   = 3'b111;
      w.flag   = 1'b1;
      if (m_mode == MODE_OFF) begin
        w.red   = FULL - CH_W'($urandom_range(0, 3));
        w.green = FULL - CH_W'($urandom_range(0, 3));
        w.blue  = FULL - CH_W'($urandom_range(0, 3));
      end else begin
        w.red   = CH_W'($urandom_range(0, 3));
        w.green = CH_W'($urandom_range(0, 3));
        w.blue  = CH_W'($urandom_range(0, 3));
      end
      push_word(w);
      w.opcode = OP_TOGGLE;
      push_word(w);
      push_ticks($urandom_range(8, 30));
    end else if (pick < 7) begin
      repeat ($urandom_range(1, 3)) begin
        w = any_word();
        if (w.opcode == OP_TICK) w.opcode = OP_SYNC;
        push_word(w);
      end
      push_ticks($urandom_range(2, 8));
    end else if (pick < 9) begin
      push_ticks($urandom_range(4, 15));
    end else begin
      // broken sequence: toggle away mid-fade, then a brightness change
      w.opcode = OP_TOGGLE;
      push_word(w);
      push_ticks($urandom_range(1, 3));
      w = any_word();
      w.opcode = OP_BRIGHT;
      push_word(w);
      push_ticks($urandom_range(1, 4));
    end
  endtask

  // All three registers, back to back; only called with nothing in flight.
  task automatic load_settings(logic [STEP_W-1:0] step, logic [WAIT_SEC_W-1:0] secs,
                               logic inv);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_STEP_PERIOD;
    cfg_data <= CFG_DATA_W'(step);
    @(posedge clk);
    mirror_config(CFG_STEP_PERIOD, CFG_DATA_W'(step));
    cfg_idx  <= CFG_WAIT_SECONDS;
    cfg_data <= CFG_DATA_W'(secs);
    @(posedge clk);
    mirror_config(CFG_WAIT_SECONDS, CFG_DATA_W'(secs));
    cfg_idx  <= CFG_INVERT;
    cfg_data <= CFG_DATA_W'(inv);
    @(posedge clk);
    mirror_config(CFG_INVERT, CFG_DATA_W'(inv));
    cfg_we   <= 1'b0;
  endtask

  initial begin : stimulus
    int phase_end;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= '0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_TICK;
    in_ch.red          <= '0;
    in_ch.green        <= '0;
    in_ch.blue         <= '0;
    in_ch.value        <= '0;
    in_ch.channel_mask <= '0;
    in_ch.flag         <= 1'b0;

    // mirror starts from the reset state
    m_step_period = STEP_W'(5);
    m_wait_secs   = WAIT_SEC_W'(60);
    m_flip_levels = 1'b0;
    m_cur         = '0;
    m_tgt         = '0;
    m_div         = CH_W'(1);
    m_mode        = MODE_OFF;
    m_fade        = 1'b1;
    m_sync        = 1'b1;
    m_play        = 1'b1;
    m_auto        = 1'b1;
    m_step_cd     = '0;
    m_wait_cd     = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) push_word(PLAN[i].cmd, PLAN[i].typed, PLAN[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // sender pauses until every word is back, then the registers change
      in_ch.valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clk);
      load_settings(PHASE_STEP[p], PHASE_SECS[p], PHASE_INV[p]);
      calm = (p == NUM_PHASES - 1);
      // stall the result side while words keep coming, so in_ch backs up
      if (p == 1 || p == 3) hold_long = 1'b1;
      phase_end = words_taken + PHASE_WORDS;
      while (words_taken < phase_end) play_scene();
    end

    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_word();
    led_word_t want;
    if (pending_levels.size() == 0) begin
      $error("result word with nothing expected");
      mismatches++;
      return;
    end
    want = pending_levels.pop_front();
    check_field("level_red", want.lvl_r, out_ch.level_red);
    check_field("level_green", want.lvl_g, out_ch.level_green);
    check_field("level_blue", want.lvl_b, out_ch.level_blue);
    check_field("mode", want.mode, out_ch.mode);
    check_field("at_target", want.at_target, out_ch.at_target);
    check_field("is_lit", want.is_lit, out_ch.is_lit);
    check_field("mode_report", want.mode_report, out_ch.mode_report);
  endfunction

  initial begin : result_side
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) check_word();
      if (hold_long) begin
        hold = LONG_HOLD;
        hold_long = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        // short random stall
        hold = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
